// ===== rtl/blpf_pkg.sv =====
// ============================================================================
// Butterworth low-pass IIR package
// Shared widths, payload types, register indexes and arithmetic helpers.
// ============================================================================
package blpf_pkg;

    // Filter order: default value and the largest order supported.
    localparam int ORDER_DEFAULT = 4;
    localparam int ORDER_MAX     = 6;

    // Field and datapath widths.
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 32;
    localparam int COEF_W     = 32;
    localparam int X_W        = 32;  // Q16.16 scaled input
    localparam int Y_W        = 48;  // Q32.16 filter output
    localparam int NUM_W      = 38;  // binomial tap times tap value
    localparam int DEN_W      = 55;  // one denominator product, Q.16
    localparam int ACC_W      = 58;  // running sum along the cell row
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_SCALED   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEN_COEF_1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEN_COEF_2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEN_COEF_3   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEN_COEF_4   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DEN_COEF_5   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DEN_COEF_6   = 3'd7;

    // Reset values of the configuration registers.
    localparam logic [GAIN_W-1:0] GAIN_RESET = 32'hFFFF_FFFF;

    // Input item.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       first_of_waveform;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       clipped;
    } t_out_item;

    // Settings that every tap needs.
    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic              scaled;
    } t_tap_cfg;

    // History control from the sequencer to the cell row.
    typedef struct packed {
        logic clear;
        logic shift;
    } t_hist_ctrl;

    // Round a Q16.16 by Q0.32 product back to Q16.16.
    function automatic logic signed [X_W-1:0] tap_round(input logic signed [63:0] p);
        logic signed [64:0] s;
        s = {p[63], p} + 65'sd2147483648;
        return s[63:32];
    endfunction

    // Binomial coefficient C(n, k) built from Pascal's triangle.
    function automatic int binom_coef(input int n, input int k);
        int row [0:ORDER_MAX];
        int i;
        int j;
        for (i = 0; i <= ORDER_MAX; i++) row[i] = 0;
        row[0] = 1;
        for (i = 1; i <= n; i++) begin
            for (j = i; j >= 1; j--) row[j] = row[j] + row[j-1];
        end
        return row[k];
    endfunction

endpackage

// ===== rtl/butterworth_lowpass_iir.sv =====
// ============================================================================
// Butterworth low-pass IIR filter, direct form I
// Order-ORDER low-pass over 16-bit samples with binomial numerator taps,
// configurable denominator coefficients and a saturating 16-bit output.
// ============================================================================
// Usage:
//   Samples enter on the input channel (i_in_valid / o_in_ready) and one
//   filtered sample leaves on the output channel (o_out_valid / i_out_ready)
//   for each one. A sample with first_of_waveform set clears both histories
//   before it is filtered.
//   One sample is in flight at a time and a new one is taken only after the
//   last has finished: the running sum ripples along the row of ORDER cells,
//   one cell a cycle, after two gain multiplications.
//   The finished sample sits in the output register; the input side is open
//   again while it waits. If the receiver stalls, the next sample is worked
//   on and then held until the output register is free.
//   Configuration registers are written through i_cfg_wr_en / i_cfg_index /
//   i_cfg_wdata; the user must do so only while the filter is idle, as the
//   block itself does not enforce it. A synchronous reset clears the
//   histories, restores the register defaults and empties the output register.
// ============================================================================
module butterworth_lowpass_iir #(
    parameter int ORDER = blpf_pkg::ORDER_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [blpf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [blpf_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  blpf_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output blpf_pkg::t_out_item                 o_out_data
);
    import blpf_pkg::*;

    localparam int DONE_CNT = ORDER + 5;
    localparam int CNT_W    = $clog2(DONE_CNT + 1);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state                  r_state;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic [GAIN_W-1:0]       r_gain;
    logic                    r_scaled;
    logic signed [COEF_W-1:0] r_den [0:ORDER_MAX-1];

    logic signed [Y_W-1:0]   r_y;
    logic                    r_y_clip;

    t_tap_cfg                tap_cfg;
    t_hist_ctrl              hist_ctrl;
    logic                    in_accept;
    logic                    out_free;
    logic                    finish;

    logic signed [X_W-1:0]   front_t0;
    logic signed [ACC_W-1:0] acc_chain [0:ORDER];
    logic signed [X_W-1:0]   x_chain   [0:ORDER];
    logic signed [Y_W-1:0]   y_chain   [0:ORDER];

    logic signed [ACC_W-1:0] acc_last;
    logic                    y_ovf;
    logic signed [Y_W:0]     o_sum;
    logic signed [32:0]      o_wide;
    logic                    o_ovf;
    t_out_item               n_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_RESET;
            r_scaled <= 1'b0;
            for (int i = 0; i < ORDER_MAX; i++) r_den[i] <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_INPUT_GAIN: r_gain   <= i_cfg_wdata;
                CFG_NUM_SCALED: r_scaled <= i_cfg_wdata[0];
                CFG_DEN_COEF_1: r_den[0] <= i_cfg_wdata;
                CFG_DEN_COEF_2: r_den[1] <= i_cfg_wdata;
                CFG_DEN_COEF_3: r_den[2] <= i_cfg_wdata;
                CFG_DEN_COEF_4: r_den[3] <= i_cfg_wdata;
                CFG_DEN_COEF_5: r_den[4] <= i_cfg_wdata;
                CFG_DEN_COEF_6: r_den[5] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign tap_cfg.gain   = r_gain;
    assign tap_cfg.scaled = r_scaled;

    // Handshakes and history control.
    assign o_in_ready      = (r_state == ST_IDLE);
    assign in_accept       = i_in_valid && o_in_ready;
    assign out_free        = !r_out_valid || i_out_ready;
    assign finish          = (r_state == ST_RUN) && (r_cnt == CNT_W'(DONE_CNT)) && out_free;
    assign hist_ctrl.clear = in_accept && i_in_data.first_of_waveform;
    assign hist_ctrl.shift = finish;

    // Input scaling and leading tap.
    blpf_front u_front (
        .i_clk    (i_clk),
        .i_load   (in_accept),
        .i_sample (i_in_data.sample_in),
        .i_cfg    (tap_cfg),
        .o_x      (x_chain[0]),
        .o_t0     (front_t0)
    );

    assign acc_chain[0] = ACC_W'(front_t0);
    assign y_chain[0]   = r_y;

    // Row of cells, one per delay.
    for (genvar k = 1; k <= ORDER; k++) begin : g_cell
        blpf_cell #(
            .ORDER (ORDER),
            .K     (k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (hist_ctrl),
            .i_cfg      (tap_cfg),
            .i_den_coef (r_den[k-1]),
            .i_x_prev   (x_chain[k-1]),
            .i_y_prev   (y_chain[k-1]),
            .i_acc      (acc_chain[k-1]),
            .o_x        (x_chain[k]),
            .o_y        (y_chain[k]),
            .o_acc      (acc_chain[k])
        );
    end

    // Wide output saturated to 48 bits.
    assign acc_last = acc_chain[ORDER];
    assign y_ovf    = (acc_last[ACC_W-1:Y_W-1] != {(ACC_W-Y_W+1){acc_last[ACC_W-1]}});

    always_ff @(posedge i_clk) begin
        if (y_ovf) begin
            r_y <= acc_last[ACC_W-1] ? {1'b1, {(Y_W-1){1'b0}}} : {1'b0, {(Y_W-1){1'b1}}};
        end else begin
            r_y <= acc_last[Y_W-1:0];
        end
        r_y_clip <= y_ovf;
    end

    // Round to a 16-bit sample and saturate.
    assign o_sum  = {r_y[Y_W-1], r_y} + 49'sd32768;
    assign o_wide = o_sum[48:16];
    assign o_ovf  = (o_wide[32:15] != {18{o_wide[32]}});

    always_comb begin
        n_out.sample_out = o_wide[15:0];
        if (o_ovf) begin
            n_out.sample_out = o_wide[32] ? 16'sh8000 : 16'sh7FFF;
        end
        n_out.clipped = r_y_clip || o_ovf;
    end

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_state <= ST_RUN;
                        r_cnt   <= '0;
                    end
                end
                ST_RUN: begin
                    if (finish) begin
                        r_state <= ST_IDLE;
                    end else if (r_cnt != CNT_W'(DONE_CNT)) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (finish) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A transfer in starts the count from zero.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == ST_RUN) && (r_cnt == '0))
        else $error("count did not restart on an input transfer");

    // The count never passes the point where the result is ready.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DONE_CNT))
        else $error("sequencer count beyond its end");

    // Finishing a sample fills the output register and reopens the input.
    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> r_out_valid && o_in_ready)
        else $error("finished sample not delivered to the output register");

    // A clipped result always carries a full-scale sample.
    a_clip_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.clipped) |->
            (r_out.sample_out == 16'sh7FFF) || (r_out.sample_out == 16'sh8000))
        else $error("clipped flag without a saturated sample");

endmodule

// ===== rtl/blpf_front.sv =====
// ============================================================================
// Butterworth low-pass IIR input stage
// Scales the accepted sample by the input gain and forms the leading tap.
// ============================================================================
module blpf_front (
    input  logic                            i_clk,
    input  logic                            i_load,
    input  logic signed [blpf_pkg::SAMPLE_W-1:0] i_sample,
    input  blpf_pkg::t_tap_cfg              i_cfg,
    output logic signed [blpf_pkg::X_W-1:0] o_x,
    output logic signed [blpf_pkg::X_W-1:0] o_t0
);
    import blpf_pkg::*;

    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [48:0]         r_prod;
    logic signed [X_W-1:0]      r_x;
    logic signed [63:0]         r_xg;
    logic signed [X_W-1:0]      r_t0;

    logic signed [GAIN_W:0]     gain_s;
    logic signed [48:0]         prod_full;
    logic signed [48:0]         x_sum;
    logic signed [64:0]         xg_full;

    // Unsigned gain seen as a positive signed operand.
    assign gain_s    = {1'b0, i_cfg.gain};
    assign prod_full = r_sample * gain_s;
    assign x_sum     = r_prod + 49'sd32768;
    assign xg_full   = r_x * gain_s;

    // Sample register, then gain product, rounding, second gain product and tap.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sample <= i_sample;
        end
        r_prod <= prod_full;
        r_x    <= x_sum[47:16];
        r_xg   <= xg_full[63:0];
        r_t0   <= i_cfg.scaled ? tap_round(r_xg) : r_x;
    end

    assign o_x  = r_x;
    assign o_t0 = r_t0;

endmodule

// ===== rtl/blpf_cell.sv =====
// ============================================================================
// Butterworth low-pass IIR cell
// Holds one delayed input and output, forms its numerator and denominator
// terms and adds them to the running sum handed on from its neighbour.
// ============================================================================
module blpf_cell #(
    parameter int ORDER = blpf_pkg::ORDER_DEFAULT,
    parameter int K     = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  blpf_pkg::t_hist_ctrl              i_ctrl,
    input  blpf_pkg::t_tap_cfg                i_cfg,
    input  logic signed [blpf_pkg::COEF_W-1:0] i_den_coef,
    input  logic signed [blpf_pkg::X_W-1:0]   i_x_prev,
    input  logic signed [blpf_pkg::Y_W-1:0]   i_y_prev,
    input  logic signed [blpf_pkg::ACC_W-1:0] i_acc,
    output logic signed [blpf_pkg::X_W-1:0]   o_x,
    output logic signed [blpf_pkg::Y_W-1:0]   o_y,
    output logic signed [blpf_pkg::ACC_W-1:0] o_acc
);
    import blpf_pkg::*;

    localparam int                 BINOM   = binom_coef(ORDER, K);
    localparam logic signed [6:0]  BINOM_S = 7'(BINOM);

    logic signed [X_W-1:0]   r_x_hist;
    logic signed [Y_W-1:0]   r_y_hist;
    logic signed [63:0]      r_mx;
    logic signed [55:0]      r_mh;
    logic signed [56:0]      r_ml;
    logic signed [X_W-1:0]   r_t;
    logic signed [NUM_W-1:0] r_num;
    logic signed [DEN_W-1:0] r_den;
    logic signed [ACC_W-1:0] r_acc;

    logic signed [GAIN_W:0]  gain_s;
    logic signed [23:0]      y_hi;
    logic signed [24:0]      y_lo;
    logic signed [64:0]      mx_full;
    logic signed [55:0]      mh_full;
    logic signed [56:0]      ml_full;
    logic signed [56:0]      z;
    logic signed [ACC_W-1:0] n_acc;

    // History entry: cleared at the start of a waveform, shifted after a sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_hist <= '0;
            r_y_hist <= '0;
        end else if (i_ctrl.clear) begin
            r_x_hist <= '0;
            r_y_hist <= '0;
        end else if (i_ctrl.shift) begin
            r_x_hist <= i_x_prev;
            r_y_hist <= i_y_prev;
        end
    end

    // Products: tap gain, and the output split into a signed high and an
    // unsigned low part so that each multiplier stays near 32 by 24 bits.
    assign gain_s  = {1'b0, i_cfg.gain};
    assign y_hi    = r_y_hist[47:24];
    assign y_lo    = {1'b0, r_y_hist[23:0]};
    assign mx_full = r_x_hist * gain_s;
    assign mh_full = i_den_coef * y_hi;
    assign ml_full = i_den_coef * y_lo;

    // The low 24 bits of the low product never carry into the floored Q.16
    // result, so the two halves recombine with one add and a two-bit shift.
    assign z = {r_mh[55], r_mh} + {{24{r_ml[56]}}, r_ml[56:24]};

    assign n_acc = i_acc + ACC_W'(r_num) - ACC_W'(r_den);

    // Term pipeline and the running sum.
    always_ff @(posedge i_clk) begin
        r_mx  <= mx_full[63:0];
        r_mh  <= mh_full;
        r_ml  <= ml_full;
        r_t   <= i_cfg.scaled ? tap_round(r_mx) : r_x_hist;
        r_den <= z[56:2];
        r_num <= NUM_W'(r_t) * NUM_W'(BINOM_S);
        r_acc <= n_acc;
    end

    assign o_x   = r_x_hist;
    assign o_y   = r_y_hist;
    assign o_acc = r_acc;

endmodule
